### hdl/life_cell_next_generation_macros.svh
// assertion macros for the next generation engine
`ifndef LIFE_CELL_NEXT_GENERATION_MACROS_SVH
`define LIFE_CELL_NEXT_GENERATION_MACROS_SVH

`ifndef SYNTHESIS
`define LCNG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same cycle check failed");
`define LCNG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next cycle check failed");
`else
`define LCNG_ASSERT_SAME(lbl, ante, cons)
`define LCNG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/lcng_pkg.sv
package lcng_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int DIM_W       = 11;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS) > 0 ? $clog2(MAX_ROWS) : 1;
  localparam int WARM_W      = $clog2(MAX_COLUMNS + 2);
  localparam int CFG_INDEX_W = 1;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  localparam logic [CFG_INDEX_W-1:0] REG_BOARD_ROWS    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOARD_COLUMNS = 1'd1;

  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // bit 0 newest, bit 2 oldest
  typedef logic [2:0] row_taps_t;

  typedef struct packed {
    row_taps_t top;
    row_taps_t mid;
    row_taps_t bot;
  } window_t;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nbr_mask_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

### hdl/lcng_in_if.sv
interface lcng_in_if;
  logic valid;
  logic ready;
  logic op;
  logic cell_alive;

  modport source (output valid, output op, output cell_alive, input ready);
  modport sink (input valid, input op, input cell_alive, output ready);
endinterface

### hdl/lcng_out_if.sv
interface lcng_out_if;
  logic valid;
  logic ready;
  logic next_alive;
  logic board_last;

  modport source (output valid, output next_alive, output board_last, input ready);
  modport sink (input valid, input next_alive, input board_last, output ready);
endinterface

### hdl/lcng_cfg_if.sv
interface lcng_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lcng_pkg::CFG_INDEX_W-1:0] index;
  logic [lcng_pkg::DIM_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/lcng_line_cell.sv
module lcng_line_cell (
  input  logic                      clk,
  input  logic                      push,
  input  logic [lcng_pkg::COL_W-1:0] wr_addr,
  input  logic [lcng_pkg::COL_W-1:0] rd_addr,
  input  logic                      d_in,
  output lcng_pkg::row_taps_t        taps
);
  import lcng_pkg::*;

  logic       line_mem [MAX_COLUMNS];
  logic       head_r;
  logic [1:0] older_r;

  // one board row of delay, write lags read by one column
  always_ff @(posedge clk) begin
    if (push) begin
      line_mem[wr_addr] <= d_in;
      if (wr_addr == rd_addr) begin
        head_r <= d_in;
      end else begin
        head_r <= line_mem[rd_addr];
      end
      older_r <= {older_r[0], head_r};
    end
  end

  assign taps = {older_r[1], older_r[0], head_r};

endmodule

### hdl/lcng_rule.sv
module lcng_rule (
  input  lcng_pkg::window_t   win,
  input  lcng_pkg::nbr_mask_t nb,
  output logic               alive
);
  import lcng_pkg::*;

  logic [3:0] count;
  logic       centre;

  assign centre = win.mid[1];

  assign count = {3'b0, win.top[2] & nb.up   & nb.left}
               + {3'b0, win.top[1] & nb.up}
               + {3'b0, win.top[0] & nb.up   & nb.right}
               + {3'b0, win.mid[2] & nb.left}
               + {3'b0, win.mid[0] & nb.right}
               + {3'b0, win.bot[2] & nb.down & nb.left}
               + {3'b0, win.bot[1] & nb.down}
               + {3'b0, win.bot[0] & nb.down & nb.right};

  // b3/s23
  assign alive = (count == 4'd3) || (centre && (count == 4'd2));

endmodule

### hdl/life_cell_next_generation.sv
// Next generation engine for a bounded, non-wrapping life board (rule B3/S23).
// Cells of one generation enter in row-major order, one transfer per cycle
// sustained; a cell transfer may follow in every cycle and the block keeps
// that rate as long as the result side takes a transfer each cycle. The
// result of a cell comes out with the push that is columns+1 cells later;
// that push registers it in the s1 stage, and it moves on into the
// output register once that register is free. Two line buffers of
// MAX_COLUMNS one-bit entries (one memory per window row above the newest)
// and a 3x3 window of flops give the neighbourhood for each push. After the
// last cell, send columns+1 drain ticks (or further cells, which are taken
// as dead) to flush the last row; the final result carries board_last and
// the block is then ready for the next board. A configuration write restarts
// the board; values of 0 are taken as 1 and values above the maximum as the
// maximum. No clearing pass runs after reset.
`include "life_cell_next_generation_macros.svh"

module life_cell_next_generation (
  input logic        clk,
  input logic        rst_n,
  lcng_in_if.sink    in_ch,
  lcng_out_if.source out_ch,
  lcng_cfg_if.sink   cfg_ch
);
  import lcng_pkg::*;

  logic [DIM_W-1:0]  rows_r, rows_nxt;
  logic [DIM_W-1:0]  cols_r, cols_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic              done_r, done_nxt;
  logic [WARM_W-1:0] warm_r, warm_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [COL_W-1:0]  col_prev_r;
  row_taps_t         bot_r;
  nbr_mask_t         s1_nb_r;
  logic              s1_last_r;
  logic              out_alive_r;
  logic              out_last_r;

  logic [DIM_W-1:0]  rows_dec;
  logic [DIM_W-1:0]  cols_dec;
  logic [ROW_W-1:0]  rows_m1;
  logic [COL_W-1:0]  cols_m1;
  logic              accept;
  logic              push;
  logic              push_bit;
  logic              emit;
  logic              last_now;
  nbr_mask_t         nb_now;
  logic              out_free;
  logic              s1_adv;
  logic              out_take;
  logic              restart;
  logic              cfg_wr;
  window_t           win;
  row_taps_t         mid_taps;
  row_taps_t         top_taps;
  logic              rule_alive;

  assign rows_dec = rows_r - DIM_W'(1);
  assign cols_dec = cols_r - DIM_W'(1);
  assign rows_m1  = rows_dec[ROW_W-1:0];
  assign cols_m1  = cols_dec[COL_W-1:0];

  assign out_take = out_valid_r && out_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && out_free;

  assign in_ch.ready  = !s1_valid_r || out_free;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  assign accept   = in_ch.valid && in_ch.ready;
  // once the board is complete every item pushes a dead cell
  assign push     = accept && (done_r || (in_ch.op == OP_CELL));
  assign push_bit = done_r ? 1'b0 : in_ch.cell_alive;
  assign emit     = (warm_r > WARM_W'(cols_r));
  assign last_now = (out_row_r == rows_m1) && (out_col_r == cols_m1);
  assign restart  = push && emit && last_now;

  assign nb_now.up    = (out_row_r != '0);
  assign nb_now.down  = (out_row_r != rows_m1);
  assign nb_now.left  = (out_col_r != '0);
  assign nb_now.right = (out_col_r != cols_m1);

  always_comb begin
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    done_nxt      = done_r;
    warm_nxt      = warm_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;

    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    if (push) begin
      s1_valid_nxt = emit;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    if (push) begin
      // column keeps cycling during drain so the line buffers stay aligned
      in_col_nxt = (in_col_r == cols_m1) ? '0 : in_col_r + COL_W'(1);
      if (!done_r && (in_col_r == cols_m1)) begin
        if (in_row_r == rows_m1) begin
          done_nxt = 1'b1;
        end else begin
          in_row_nxt = in_row_r + ROW_W'(1);
        end
      end
      if (!emit) begin
        warm_nxt = warm_r + WARM_W'(1);
      end else begin
        if (out_col_r == cols_m1) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end

    if (restart || cfg_wr) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      done_nxt    = 1'b0;
      warm_nxt    = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end

    if (cfg_wr) begin
      unique case (cfg_ch.index)
        REG_BOARD_ROWS: begin
          rows_nxt = clamp_dim(cfg_ch.data, DIM_W'(MAX_ROWS));
        end
        REG_BOARD_COLUMNS: begin
          cols_nxt = clamp_dim(cfg_ch.data, DIM_W'(MAX_COLUMNS));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= DIM_RESET;
      cols_r      <= DIM_RESET;
      in_col_r    <= '0;
      in_row_r    <= '0;
      done_r      <= 1'b0;
      warm_r      <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      done_r      <= done_nxt;
      warm_r      <= warm_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      col_prev_r <= in_col_r;
      bot_r      <= {bot_r[1:0], push_bit};
      s1_nb_r    <= nb_now;
      s1_last_r  <= last_now;
    end
    if (s1_adv) begin
      out_alive_r <= rule_alive;
      out_last_r  <= s1_last_r;
    end
  end

  // window rows chained through the line buffers
  lcng_line_cell u_mid_cell (
    .clk     (clk),
    .push    (push),
    .wr_addr (col_prev_r),
    .rd_addr (in_col_r),
    .d_in    (bot_r[0]),
    .taps    (mid_taps)
  );

  lcng_line_cell u_top_cell (
    .clk     (clk),
    .push    (push),
    .wr_addr (col_prev_r),
    .rd_addr (in_col_r),
    .d_in    (mid_taps[0]),
    .taps    (top_taps)
  );

  assign win.top = top_taps;
  assign win.mid = mid_taps;
  assign win.bot = bot_r;

  lcng_rule u_rule (
    .win   (win),
    .nb    (s1_nb_r),
    .alive (rule_alive)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.next_alive = out_alive_r;
  assign out_ch.board_last = out_last_r;

  `LCNG_ASSERT_SAME(a_stall_blocks_input, s1_valid_r && out_valid_r && !out_ch.ready, !in_ch.ready)
  `LCNG_ASSERT_NEXT(a_warmup_no_result, push && !emit, !s1_valid_r)
  `LCNG_ASSERT_NEXT(a_last_restarts, restart && !cfg_wr, (warm_r == '0) && !done_r)
  `LCNG_ASSERT_NEXT(a_advance_fills_out, s1_adv, out_valid_r)

endmodule
